@@ sv/fcf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fcf_pkg;

  localparam int FORCE_BITS = 16;
  localparam int ADM_BITS   = 16;
  localparam int MAG_BITS   = 15;
  localparam int NUM_AXES   = 3;
  localparam int IDX_BITS   = 3;

  // Register indexes of the configuration port
  localparam logic [IDX_BITS-1:0] REG_OFFSET_X    = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_OFFSET_Y    = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_OFFSET_Z    = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_ADMITTANCE  = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_FORCE_GOAL  = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_FORCE_LIMIT = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_DEAD_BAND   = 3'd6;

  // Reset values
  localparam logic [ADM_BITS-1:0] ADM_RESET   = 16'd2621;
  localparam logic [MAG_BITS-1:0] GOAL_RESET  = 15'd2560;
  localparam logic [MAG_BITS-1:0] LIMIT_RESET = 15'd2560;
  localparam logic [MAG_BITS-1:0] DBAND_RESET = 15'd768;

  // Per-axis update modes chosen by the classify stage
  localparam logic [1:0] MODE_DECAY = 2'd0;
  localparam logic [1:0] MODE_TRACK = 2'd1;
  localparam logic [1:0] MODE_HOLD  = 2'd2;

  typedef logic signed [FORCE_BITS-1:0] force_t;

  typedef struct packed {
    force_t                offset_x;
    force_t                offset_y;
    force_t                offset_z;
    logic [ADM_BITS-1:0]   admittance;
    logic [MAG_BITS-1:0]   force_goal;
    logic [MAG_BITS-1:0]   force_limit;
    logic [MAG_BITS-1:0]   dead_band;
  } cfg_t;

  typedef struct packed {
    logic load_s1;
    logic load_out;
  } lane_ctrl_t;

endpackage

`default_nettype wire

@@ sv/fcf_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fcf_cfg (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [fcf_pkg::IDX_BITS-1:0]    cfg_index,
  input  wire  [fcf_pkg::FORCE_BITS-1:0]  cfg_data,
  output fcf_pkg::cfg_t                   cfg_regs
);
  import fcf_pkg::*;

  cfg_t regs_r;
  cfg_t regs_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_regs  = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_OFFSET_X:    regs_nxt.offset_x    = cfg_data;
        REG_OFFSET_Y:    regs_nxt.offset_y    = cfg_data;
        REG_OFFSET_Z:    regs_nxt.offset_z    = cfg_data;
        REG_ADMITTANCE:  regs_nxt.admittance  = cfg_data;
        REG_FORCE_GOAL:  regs_nxt.force_goal  = cfg_data[MAG_BITS-1:0];
        REG_FORCE_LIMIT: regs_nxt.force_limit = cfg_data[MAG_BITS-1:0];
        REG_DEAD_BAND:   regs_nxt.dead_band   = cfg_data[MAG_BITS-1:0];
        default:         regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.offset_x    <= '0;
      regs_r.offset_y    <= '0;
      regs_r.offset_z    <= '0;
      regs_r.admittance  <= ADM_RESET;
      regs_r.force_goal  <= GOAL_RESET;
      regs_r.force_limit <= LIMIT_RESET;
      regs_r.dead_band   <= DBAND_RESET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/fcf_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fcf_lane (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire fcf_pkg::lane_ctrl_t ctrl,
  input  wire fcf_pkg::force_t     raw,
  input  wire fcf_pkg::force_t     offset,
  input  wire fcf_pkg::cfg_t       cfg_regs,
  output fcf_pkg::force_t          cmd
);
  import fcf_pkg::*;

  localparam int FB = FORCE_BITS;

  // Classify stage
  logic signed [FB:0]   corr;
  force_t               f;
  logic [FB-1:0]        mag;
  logic                 f_neg;
  logic [1:0]           mode_nxt;
  force_t               target_nxt;
  logic [1:0]           mode_r;
  force_t               target_r;

  always_comb begin
    corr = {offset[FB-1], offset} - {raw[FB-1], raw};
    if (corr[FB] != corr[FB-1]) begin
      f = corr[FB] ? {1'b1, {(FB-1){1'b0}}} : {1'b0, {(FB-1){1'b1}}};
    end else begin
      f = corr[FB-1:0];
    end
    f_neg = f[FB-1];
    // The magnitude of the most negative value still fits unsigned.
    mag   = f_neg ? (~f + 1'b1) : f;

    if (mag <= {1'b0, cfg_regs.dead_band}) begin
      mode_nxt   = MODE_DECAY;
      target_nxt = '0;
    end else if (mag < {1'b0, cfg_regs.force_limit}) begin
      mode_nxt   = MODE_TRACK;
      target_nxt = f_neg ? force_t'({1'b0, cfg_regs.force_goal})
                         : force_t'(-$signed({1'b0, cfg_regs.force_goal}));
    end else begin
      mode_nxt   = MODE_HOLD;
      target_nxt = f_neg ? force_t'({1'b0, cfg_regs.force_limit})
                         : force_t'(-$signed({1'b0, cfg_regs.force_limit}));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_s1) begin
      mode_r   <= mode_nxt;
      target_r <= target_nxt;
    end
  end

  // Update stage: one multiply-accumulate against the held command
  force_t                  cmd_r;
  force_t                  cmd_nxt;
  logic signed [FB:0]      delta;
  logic signed [2*FB+1:0]  prod;
  logic signed [2*FB+1:0]  prod_rnd;
  logic signed [FB+1:0]    step;
  logic signed [FB+1:0]    sum;

  always_comb begin
    delta    = {target_r[FB-1], target_r} - {cmd_r[FB-1], cmd_r};
    prod     = $signed({1'b0, cfg_regs.admittance}) * delta;
    prod_rnd = prod + (2*FB+2)'(32768);
    step     = prod_rnd[2*FB+1:16];
    sum      = {{2{cmd_r[FB-1]}}, cmd_r} + step;
    if (mode_r == MODE_HOLD) begin
      cmd_nxt = target_r;
    end else if (sum[FB+1:FB-1] != {3{sum[FB-1]}}) begin
      cmd_nxt = sum[FB+1] ? {1'b1, {(FB-1){1'b0}}} : {1'b0, {(FB-1){1'b1}}};
    end else begin
      cmd_nxt = sum[FB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= '0;
    end else if (ctrl.load_out) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd = cmd_r;

endmodule

`default_nettype wire

@@ sv/axis_force_command_filter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Three-axis force command filter.
// Input stream: one item per force sample, in_tdata = {raw_fz, raw_fy, raw_fx}.
// Output stream: one item per input item, out_tdata = {cmd_fz, cmd_fy, cmd_fx},
// the commands held after that sample's update.
// Configuration: cfg_index selects one of seven registers (offsets x/y/z,
// admittance, force goal, force limit, dead band); cfg_data is the value.
// Writes are always taken and should happen only while no item is in flight.
// An accepted item is registered in the classify stage, then in the output
// register. Throughput: one item per cycle while out_tready is high, set by
// one multiply-accumulate per cycle on the held command in each axis's lane.
// The output register doubles as the command register, and a classify stage
// in front of it accepts a new item while a finished result waits.
// When the receiver stalls, the classify stage fills and in_tready drops.
// Reset clears all commands to zero, empties both stages and loads the
// default register values.
module axis_force_command_filter_unit (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [47:0]                     in_tdata,   // raw_fx, raw_fy, raw_fz
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [47:0]                     out_tdata,  // cmd_fx, cmd_fy, cmd_fz
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [fcf_pkg::IDX_BITS-1:0]    cfg_index,
  input  wire  [fcf_pkg::FORCE_BITS-1:0]  cfg_data
);
  import fcf_pkg::*;

  cfg_t       cfg_regs;
  lane_ctrl_t ctrl;
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;
  force_t     raw   [NUM_AXES];
  force_t     off   [NUM_AXES];
  force_t     cmd   [NUM_AXES];

  fcf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_regs  (cfg_regs)
  );

  assign out_free      = !out_valid_r || out_tready;
  assign in_tready     = !s1_valid_r || out_free;
  assign ctrl.load_s1  = in_tvalid && in_tready;
  assign ctrl.load_out = s1_valid_r && out_free;

  assign s1_valid_nxt  = ctrl.load_s1 ? 1'b1 : (ctrl.load_out ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = ctrl.load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign off[0] = cfg_regs.offset_x;
  assign off[1] = cfg_regs.offset_y;
  assign off[2] = cfg_regs.offset_z;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    assign raw[a] = in_tdata[a*FORCE_BITS +: FORCE_BITS];

    fcf_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .raw      (raw[a]),
      .offset   (off[a]),
      .cfg_regs (cfg_regs),
      .cmd      (cmd[a])
    );

    assign out_tdata[a*FORCE_BITS +: FORCE_BITS] = cmd[a];
  end

  assign out_tvalid = out_valid_r;

  // A full classify stage behind a stalled output must block the input.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while both stages are held");

  // Commands only change when a new result is loaded.
  a_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl.load_out |=> $stable(out_tdata))
    else $error("command changed without a result being loaded");

  // Every accepted item reaches the classify stage.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_s1 |=> s1_valid_r)
    else $error("accepted item lost in classify stage");

  // Reset leaves zero commands and no pending result.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (out_tdata == '0 && !out_tvalid))
    else $error("reset did not clear the commands");

endmodule

`default_nettype wire
